### rtl/core/stoc_pkg.sv
// ----------------------------------------------------------------------------
// stoc_pkg - shared types and codes for the self-trade order check
// Request and result codes, the stored entry layout and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package stoc_pkg;

  // Request function codes
  localparam logic FUNC_CHECK  = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Order side codes
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_SELF_TRADE = 2'd1;
  localparam logic [1:0] STATUS_FULL       = 2'd2;

  // One table entry as held in the memory
  typedef struct packed {
    logic        valid;
    logic [15:0] account;
    logic [31:0] ord_ref;
    logic [31:0] instrument;
    logic        side;
    logic [31:0] price;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_we;  // clearing pass: write an empty entry
    logic start;   // request beat accepted, capture it
    logic rd_en;   // issue a table read
    logic scan;    // evaluate read data of the running scan
    logic commit;  // load the result and update the table
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_stop;  // scan has seen the last slot or a deciding match
    logic out_free;   // result register can take a new result
  } dp_sts_t;

endpackage

### rtl/core/self_trade_order_check.sv
// ----------------------------------------------------------------------------
// self_trade_order_check - self-trade prevention table
// Keeps live orders and flags new orders that would cross an order of the
// same account and instrument on the opposite side.
// ----------------------------------------------------------------------------
// After reset the block clears its order table, one slot a cycle, with
// in_ready low. One request is then handled at a time: the table sits in a
// memory with one write and one registered read port that is read one slot a
// cycle, so out_valid rises once the scan ends (the scan of a check stops
// early at the first self-trade, a remove stops at the slot holding its pair)
// and an earlier result still waiting in the output register has been taken.
// in_ready comes back in the cycle after the result is loaded, so the block
// takes no new request before the last one's result is loaded. A finished
// result waits in the output register while the next request is accepted.
// Status 0 means accepted or removed, 1 a self-trade (with the lowest
// matching slot's reference), 2 a full table.
module self_trade_order_check
  import stoc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [15:0] in_account_id,
  input  logic [31:0] in_ord_ref,
  input  logic [31:0] in_instrument_id,
  input  logic [31:0] in_price_ticks,
  input  logic        in_side,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_opposite_ref
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  ctrl_cmd_t     cmd;
  dp_sts_t       sts;
  logic [AW-1:0] addr;

  stoc_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr)
  );

  stoc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .addr             (addr),
    .sts              (sts),
    .in_func          (in_func),
    .in_account_id    (in_account_id),
    .in_ord_ref       (in_ord_ref),
    .in_instrument_id (in_instrument_id),
    .in_price_ticks   (in_price_ticks),
    .in_side          (in_side),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_opposite_ref (out_opposite_ref)
  );

endmodule

### rtl/core/stoc_ctrl.sv
// ----------------------------------------------------------------------------
// stoc_ctrl - sequencer for the self-trade order check
// Runs the clearing pass after reset, accepts requests, walks the table
// addresses one slot per cycle and commits the result.
// ----------------------------------------------------------------------------
module stoc_ctrl
  import stoc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int AW            = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dp_sts_t       sts,
  output ctrl_cmd_t     cmd,
  output logic [AW-1:0] addr
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  state_t        state_r;
  logic [AW-1:0] addr_r;

  // State and address counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r  <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          if (addr_r == LAST) begin
            state_r <= ST_IDLE;
            addr_r  <= '0;
          end else begin
            addr_r <= addr_r + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_SCAN;
            addr_r  <= '0;
          end
        end
        ST_SCAN: begin
          if (sts.scan_stop) begin
            state_r <= ST_DONE;
          end else if (addr_r != LAST) begin
            addr_r <= addr_r + AW'(1);
          end
        end
        ST_DONE: begin
          if (sts.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
          addr_r  <= '0;
        end
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd.clr_we = (state_r == ST_CLEAR);
    cmd.start  = (state_r == ST_IDLE) && in_valid;
    cmd.rd_en  = (state_r == ST_SCAN);
    cmd.scan   = (state_r == ST_SCAN);
    cmd.commit = (state_r == ST_DONE) && sts.out_free;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign addr     = addr_r;

endmodule

### rtl/core/stoc_datapath.sv
// ----------------------------------------------------------------------------
// stoc_datapath - order table and compare logic of the self-trade check
// Holds the order memory, the captured request, the per-slot compare, the
// scan flags and the result register.
// ----------------------------------------------------------------------------
module stoc_datapath
  import stoc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int AW            = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctrl_cmd_t     cmd,
  input  logic [AW-1:0] addr,
  output dp_sts_t       sts,
  input  logic          in_func,
  input  logic [15:0]   in_account_id,
  input  logic [31:0]   in_ord_ref,
  input  logic [31:0]   in_instrument_id,
  input  logic [31:0]   in_price_ticks,
  input  logic          in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [31:0]   out_opposite_ref
);

  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  // Order memory, one write and one registered read port
  entry_t        mem [TABLE_ENTRIES];
  entry_t        rd_data_r;
  logic [AW-1:0] eval_idx_r;
  logic          eval_vld_r;

  // Captured request
  logic        req_func_r;
  logic [15:0] req_acct_r;
  logic [31:0] req_ref_r;
  logic [31:0] req_instr_r;
  logic [31:0] req_price_r;
  logic        req_side_r;

  // Scan flags
  logic          hit_r;
  logic [31:0]   hit_ref_r;
  logic          pair_r;
  logic [AW-1:0] pair_slot_r;
  logic          free_r;
  logic [AW-1:0] free_slot_r;

  // Result register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_opp_r;

  logic          acct_eq;
  logic          pair_now;
  logic          trade_now;
  logic          price_ok;
  logic          upd;
  logic          wr_sel;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;
  logic [1:0]    res_status;
  logic [31:0]   res_opp;

  // Slot compare on the registered read data
  always_comb begin
    acct_eq   = rd_data_r.valid && (rd_data_r.account == req_acct_r);
    pair_now  = acct_eq && (rd_data_r.ord_ref == req_ref_r);
    price_ok  = (req_side_r == SIDE_BUY) ? (req_price_r >= rd_data_r.price)
                                         : (req_price_r <= rd_data_r.price);
    trade_now = acct_eq && (rd_data_r.instrument == req_instr_r) &&
                (rd_data_r.side != req_side_r) && price_ok;
    upd       = cmd.scan && eval_vld_r;
  end

  // Stop at the last slot, or at the first deciding match
  always_comb begin
    sts.scan_stop = upd && ((eval_idx_r == LAST) ||
                            ((req_func_r == FUNC_CHECK) ? trade_now : pair_now));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Result and table update decision
  always_comb begin
    res_opp = '0;
    if (req_func_r == FUNC_REMOVE) begin
      res_status = STATUS_OK;
      wr_sel     = pair_r;
    end else if (hit_r) begin
      res_status = STATUS_SELF_TRADE;
      res_opp    = hit_ref_r;
      wr_sel     = 1'b0;
    end else if (pair_r) begin
      res_status = STATUS_OK;
      wr_sel     = 1'b0;
    end else if (free_r) begin
      res_status = STATUS_OK;
      wr_sel     = 1'b1;
    end else begin
      res_status = STATUS_FULL;
      wr_sel     = 1'b0;
    end
  end

  // Write port: clearing pass, insert into free slot or remove matched pair
  always_comb begin
    we            = cmd.clr_we || (cmd.commit && wr_sel);
    wd.valid      = !cmd.clr_we && (req_func_r == FUNC_CHECK);
    wd.account    = req_acct_r;
    wd.ord_ref    = req_ref_r;
    wd.instrument = req_instr_r;
    wd.side       = req_side_r;
    wd.price      = req_price_r;
    if (cmd.clr_we) begin
      wa = addr;
    end else if (req_func_r == FUNC_REMOVE) begin
      wa = pair_slot_r;
    end else begin
      wa = free_slot_r;
    end
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rd_data_r  <= mem[addr];
      eval_idx_r <= addr;
    end
  end

  // Read pipeline valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_vld_r <= 1'b0;
    end else begin
      eval_vld_r <= cmd.rd_en;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_func_r  <= in_func;
      req_acct_r  <= in_account_id;
      req_ref_r   <= in_ord_ref;
      req_instr_r <= in_instrument_id;
      req_price_r <= in_price_ticks;
      req_side_r  <= in_side;
    end
  end

  // Scan flags, first match of each kind is kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      pair_r <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.start) begin
      hit_r  <= 1'b0;
      pair_r <= 1'b0;
      free_r <= 1'b0;
    end else if (upd) begin
      if (trade_now && !hit_r) begin
        hit_r     <= 1'b1;
        hit_ref_r <= rd_data_r.ord_ref;
      end
      if (pair_now && !pair_r) begin
        pair_r      <= 1'b1;
        pair_slot_r <= eval_idx_r;
      end
      if (!rd_data_r.valid && !free_r) begin
        free_r      <= 1'b1;
        free_slot_r <= eval_idx_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_opp_r    <= res_opp;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_opposite_ref = out_opp_r;

endmodule

### rtl/core/stoc_checker.sv
// ----------------------------------------------------------------------------
// stoc_checker - port-level checks for the self-trade order check
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module stoc_checker
  import stoc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_opposite_ref
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_opposite_ref))
    else $error("result beat changed while stalled");

  // Only defined status codes are shown
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK) || (out_status == STATUS_SELF_TRADE) ||
                  (out_status == STATUS_FULL))
    else $error("undefined status code");

  // Reference is zero unless a self-trade is reported
  a_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_SELF_TRADE) |-> out_opposite_ref == 32'd0)
    else $error("opposite reference set without a self-trade");

  // One request at a time: busy straight after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

endmodule

bind self_trade_order_check stoc_checker u_stoc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_opposite_ref (out_opposite_ref)
);
